// ----- hdl/smq_pkg.sv -----
package smq_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SIZE_W      = 9;
    localparam int FRAC_W      = 17;
    localparam int FRAC_BITS   = FRAC_W - 1;
    localparam int PROD_W      = FRAC_BITS + CNT_W;

    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32768);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_SAMPLES);

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [FRAC_W-1:0]        frac_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic    insert;
        logic    shift;
        sample_t sample;
    } chain_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DRAIN,
        ST_MED
    } state_t;

endpackage

// ----- hdl/smq_in_if.sv -----
interface smq_in_if;
    logic             valid;
    logic             ready;
    smq_pkg::sample_t sample;
    logic             last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

// ----- hdl/smq_out_if.sv -----
interface smq_out_if;
    logic                           valid;
    logic                           ready;
    smq_pkg::sample_t               median_value;
    smq_pkg::sample_t               quantile_value;
    logic [smq_pkg::SIZE_W-1:0]     set_size;
    logic                           overflow;

    modport source (output valid, output median_value, output quantile_value,
                    output set_size, output overflow, input ready);
    modport sink (input valid, input median_value, input quantile_value,
                  input set_size, input overflow, output ready);
endinterface

// ----- hdl/smq_cell.sv -----
module smq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smq_pkg::chain_ctl_t  ctl,
    input  logic                 left_gt,
    input  logic                 left_valid,
    input  smq_pkg::sample_t     left_value,
    input  logic                 right_valid,
    input  smq_pkg::sample_t     right_value,
    output smq_pkg::sample_t     value,
    output logic                 valid,
    output logic                 gt
);

    smq_pkg::sample_t value_reg;
    smq_pkg::sample_t value_next;
    logic             valid_reg;
    logic             valid_next;
    logic             take_new;

    // stored entry sorts after the incoming sample
    assign gt       = valid_reg && (value_reg > ctl.sample);
    // first greater entry, or first empty slot, takes the new sample
    assign take_new = gt || (!valid_reg && left_valid);

    // pick next content: hold, shift up on insert, or shift down on drain
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctl.insert)
        begin
            if (left_gt)
            begin
                value_next = left_value;
                valid_next = 1'b1;
            end
            else if (take_new)
            begin
                value_next = ctl.sample;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ----- hdl/smq_chain.sv -----
module smq_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smq_pkg::chain_ctl_t  ctl,
    output smq_pkg::sample_t     head_value
);

    localparam int N = smq_pkg::MAX_SAMPLES;

    smq_pkg::sample_t val_w [N];
    logic             vld_w [N];
    logic             gt_w  [N];

    // row of cells; cell 0 holds the smallest entry
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic             l_gt;
        logic             l_vld;
        smq_pkg::sample_t l_val;
        logic             r_vld;
        smq_pkg::sample_t r_val;

        if (i == 0)
        begin : g_first
            assign l_gt  = 1'b0;
            assign l_vld = 1'b1;
            assign l_val = '0;
        end
        else
        begin : g_mid_l
            assign l_gt  = gt_w[i-1];
            assign l_vld = vld_w[i-1];
            assign l_val = val_w[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign r_vld = 1'b0;
            assign r_val = '0;
        end
        else
        begin : g_mid_r
            assign r_vld = vld_w[i+1];
            assign r_val = val_w[i+1];
        end

        smq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_gt     (l_gt),
            .left_valid  (l_vld),
            .left_value  (l_val),
            .right_valid (r_vld),
            .right_value (r_val),
            .value       (val_w[i]),
            .valid       (vld_w[i]),
            .gt          (gt_w[i])
        );
    end

    assign head_value = val_w[0];

endmodule

// ----- hdl/sorted_median_quantile_top.sv -----
// Samples without the last mark: one transaction per cycle while idle, inserted in order by
// the cell row until it is full; later ones are dropped and flagged. Closing a set runs a
// setup state (PREP), shifts the row out through cell 0 (DRAIN), then a median state (MED).
// Input is not accepted from the closing sample until the result is loaded into the output.
// Reset clears control state and valid flags of the cells; frac_reg resets to 32768.
module sorted_median_quantile_top (
    input  logic                          clk,
    input  logic                          rst_n,
    smq_in_if.sink                        samples,
    smq_out_if.source                     results,
    input  logic                          cfg_wr_en,
    input  logic [smq_pkg::FRAC_W-1:0]    cfg_wr_data
);

    smq_pkg::state_t     state_reg;
    smq_pkg::state_t     state_next;
    smq_pkg::frac_t      frac_reg;
    smq_pkg::count_t     fill_reg;
    logic                dropped_reg;
    smq_pkg::count_t     n_reg;
    smq_pkg::count_t     half_reg;
    smq_pkg::count_t     qidx_reg;
    smq_pkg::count_t     qidx_next;
    smq_pkg::count_t     idx_reg;
    smq_pkg::sample_t    lo_reg;
    smq_pkg::sample_t    hi_reg;
    smq_pkg::sample_t    q_reg;
    logic                out_valid_reg;
    smq_pkg::sample_t    med_out_reg;
    smq_pkg::sample_t    q_out_reg;
    logic [smq_pkg::SIZE_W-1:0] size_out_reg;
    logic                ovf_out_reg;

    logic                accept;
    logic                full;
    logic                drain_done;
    logic                load_out;
    smq_pkg::chain_ctl_t ctl;
    smq_pkg::sample_t    head_value;
    logic [smq_pkg::PROD_W-1:0] prod;
    smq_pkg::count_t     qraw;
    logic signed [smq_pkg::DATA_W:0] sum;
    smq_pkg::sample_t    median;

    assign samples.ready = (state_reg == smq_pkg::ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign full          = (fill_reg == smq_pkg::CNT_MAX);
    assign drain_done    = (idx_reg == n_reg - smq_pkg::count_t'(1));

    // broadcast command to the cell row
    always_comb
    begin
        ctl.insert = accept && !full;
        ctl.shift  = (state_reg == smq_pkg::ST_DRAIN);
        ctl.sample = samples.sample;
    end

    smq_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .head_value (head_value)
    );

    // next state and output load
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            smq_pkg::ST_IDLE:
            begin
                if (accept && samples.last)
                begin
                    state_next = smq_pkg::ST_PREP;
                end
            end
            smq_pkg::ST_PREP:
            begin
                state_next = smq_pkg::ST_DRAIN;
            end
            smq_pkg::ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = smq_pkg::ST_MED;
                end
            end
            smq_pkg::ST_MED:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = smq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // quantile register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= smq_pkg::FRAC_RESET;
        end
        else if (cfg_wr_en)
        begin
            frac_reg <= cfg_wr_data;
        end
    end

    // count kept samples, flag drops, empty on close
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (accept && full)
            begin
                dropped_reg <= 1'b1;
            end
            else if (load_out)
            begin
                dropped_reg <= 1'b0;
            end
            if (accept && !full)
            begin
                fill_reg <= fill_reg + smq_pkg::count_t'(1);
            end
            else if (state_reg == smq_pkg::ST_PREP)
            begin
                fill_reg <= '0;
            end
        end
    end

    // quantile index from fraction and count
    assign prod = {{smq_pkg::CNT_W{1'b0}}, frac_reg[smq_pkg::FRAC_BITS-1:0]}
                * {{smq_pkg::FRAC_BITS{1'b0}}, fill_reg};
    assign qraw = prod[smq_pkg::PROD_W-1:smq_pkg::FRAC_BITS];

    always_comb
    begin
        if (frac_reg[smq_pkg::FRAC_BITS] || (qraw >= fill_reg))
        begin
            qidx_next = fill_reg - smq_pkg::count_t'(1);
        end
        else
        begin
            qidx_next = qraw;
        end
    end

    // set up drain, then capture the wanted elements as they pass cell 0
    always_ff @(posedge clk)
    begin
        if (state_reg == smq_pkg::ST_PREP)
        begin
            n_reg    <= fill_reg;
            half_reg <= fill_reg >> 1;
            qidx_reg <= qidx_next;
            idx_reg  <= '0;
        end
        else if (state_reg == smq_pkg::ST_DRAIN)
        begin
            idx_reg <= idx_reg + smq_pkg::count_t'(1);
            if (idx_reg + smq_pkg::count_t'(1) == half_reg)
            begin
                lo_reg <= head_value;
            end
            if (idx_reg == half_reg)
            begin
                hi_reg <= head_value;
            end
            if (idx_reg == qidx_reg)
            begin
                q_reg <= head_value;
            end
        end
    end

    // median: middle element, or floored mean of the two middle elements
    assign sum    = {lo_reg[smq_pkg::DATA_W-1], lo_reg} + {hi_reg[smq_pkg::DATA_W-1], hi_reg};
    assign median = n_reg[0] ? hi_reg : smq_pkg::sample_t'(sum >>> 1);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            med_out_reg  <= median;
            q_out_reg    <= q_reg;
            size_out_reg <= n_reg[smq_pkg::SIZE_W-1:0];
            ovf_out_reg  <= dropped_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.median_value   = med_out_reg;
    assign results.quantile_value = q_out_reg;
    assign results.set_size       = size_out_reg;
    assign results.overflow       = ovf_out_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= smq_pkg::CNT_MAX)
        else $error("fill count above capacity");

    a_drain_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smq_pkg::ST_DRAIN |-> (idx_reg < n_reg) && (qidx_reg < n_reg))
        else $error("drain index beyond set size");

    a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == smq_pkg::ST_DRAIN |=>
            (state_reg == smq_pkg::ST_DRAIN) || (state_reg == smq_pkg::ST_MED))
        else $error("drain left without median step");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == smq_pkg::ST_MED))
        else $error("result raised outside median step");
`endif

endmodule
